### sv/timed_event_list_scheduler_assert.svh
// Assertion macros for the SVA checker file.
`ifndef TIMED_EVENT_LIST_SCHEDULER_ASSERT_SVH
`define TIMED_EVENT_LIST_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TELS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TELS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tels_pkg.sv
`default_nettype none

package tels_pkg;

    localparam int CAPACITY_DEF = 16;

    // config port: one 32-bit register at byte 0
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_START_TIME = '0;

    localparam logic OP_SCHED = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [31:0] event_time;
        logic [7:0]  router_id;
        logic [15:0] datagram_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic [7:0]  out_router;
        logic [15:0] out_datagram;
        logic [31:0] now_time;
        logic        last;
    } out_item_t;

    // one stored event
    typedef struct packed {
        logic [31:0] ev_time;
        logic [7:0]  router;
        logic [15:0] datagram;
    } entry_t;

endpackage

`default_nettype wire

### sv/tels_event_mem.sv
`default_nettype none

// Event storage: one write port, one read port, registered read data.
module tels_event_mem #(
    parameter int DEPTH = tels_pkg::CAPACITY_DEF,
    parameter int AW    = 4
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire tels_pkg::entry_t  wdata,
    input  wire logic [AW-1:0]     raddr,
    output tels_pkg::entry_t       rdata
);

    tels_pkg::entry_t mem [DEPTH];
    tels_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/timed_event_list_scheduler.sv
`default_nettype none

// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+-------------------------------
// command   | start, busy, item (opcode/time/rtr/dg)    | taken when start & !busy
// result    | strobe, result (kind/acc/rtr/dg/now/last) | one cycle per item, no stall
// config    | psel penable pwrite paddr pwdata prdata   | write at psel&penable&pwrite
//
// Schedule: the ack strobes the cycle after acceptance, busy stays low.
// Tick: busy while it issues the first read, evaluates each stored entry in turn
// and closes out; on an empty list it only closes out. The scan is paced by the
// single read port of the event memory, one entry per cycle. Deliveries strobe
// in stored order, the done item strobes in the first cycle busy is low again.
// Reset clears the count, start_time and the current time; memory is not cleared.
// The receiver cannot stall; every result is shown for exactly one cycle.
module timed_event_list_scheduler #(
    parameter int CAPACITY = tels_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command
    input  wire logic                          start,
    output      logic                          busy,
    input  wire tels_pkg::in_item_t            item,
    // result
    output      logic                          strobe,
    output tels_pkg::out_item_t                result,
    // config
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tels_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output      logic [31:0]                   prdata,
    output      logic                          pready
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] iss_reg, iss_next;     // next entry to read
    logic [CNT_W-1:0] wr_reg, wr_next;       // compaction write slot
    logic             dv_reg, dv_next;       // read data valid this cycle
    logic [31:0]      now_reg, now_next;
    logic [31:0]      start_time_reg, start_time_next;
    logic             strobe_reg, strobe_next;
    tels_pkg::out_item_t result_reg, result_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    tels_pkg::entry_t mem_wdata;
    tels_pkg::entry_t mem_rdata;
    logic             cfg_wr;
    logic             accept;

    tels_event_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (iss_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign busy   = (state_reg == ST_SCAN);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[tels_pkg::PADDR_W-1:2] == tels_pkg::REG_START_TIME);
    assign prdata = (paddr[tels_pkg::PADDR_W-1:2] == tels_pkg::REG_START_TIME)
                    ? start_time_reg : 32'd0;

    assign strobe = strobe_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        iss_next        = iss_reg;
        wr_next         = wr_reg;
        dv_next         = 1'b0;
        now_next        = now_reg;
        start_time_next = start_time_reg;
        strobe_next     = 1'b0;
        result_next     = '0;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata.ev_time  = item.event_time;
        mem_wdata.router   = item.router_id;
        mem_wdata.datagram = item.datagram_id;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.opcode == tels_pkg::OP_SCHED)
                    begin
                        strobe_next          = 1'b1;
                        result_next.kind     = tels_pkg::KIND_ACK;
                        result_next.now_time = now_reg;
                        result_next.last     = 1'b1;
                        if (count_reg < CAP_CNT)
                        begin
                            mem_we               = 1'b1;
                            count_next           = count_reg + 1'b1;
                            result_next.accepted = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        iss_next   = '0;
                        wr_next    = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                // evaluate the entry read last cycle
                if (dv_reg)
                begin
                    if (mem_rdata.ev_time == now_reg)
                    begin
                        strobe_next              = 1'b1;
                        result_next.kind         = tels_pkg::KIND_DELIVER;
                        result_next.out_router   = mem_rdata.router;
                        result_next.out_datagram = mem_rdata.datagram;
                        result_next.now_time     = now_reg;
                    end
                    else
                    begin
                        // keep it; wr_reg trails the read pointer, no conflict
                        mem_we    = 1'b1;
                        mem_waddr = wr_reg[AW-1:0];
                        mem_wdata = mem_rdata;
                        wr_next   = wr_reg + 1'b1;
                    end
                end
                if (iss_reg != count_reg)
                begin
                    iss_next = iss_reg + 1'b1;
                    dv_next  = 1'b1;
                end
                else if (!dv_reg)
                begin
                    state_next           = ST_IDLE;
                    count_next           = wr_reg;
                    now_next             = now_reg + 32'd1;
                    strobe_next          = 1'b1;
                    result_next.kind     = tels_pkg::KIND_DONE;
                    result_next.now_time = now_reg + 32'd1;
                    result_next.last     = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            start_time_next = pwdata;
            now_next        = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            iss_reg        <= '0;
            wr_reg         <= '0;
            dv_reg         <= 1'b0;
            now_reg        <= 32'd0;
            start_time_reg <= 32'd0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            iss_reg        <= iss_next;
            wr_reg         <= wr_next;
            dv_reg         <= dv_next;
            now_reg        <= now_next;
            start_time_reg <= start_time_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

### sv/tels_checker.sv
`default_nettype none

`include "timed_event_list_scheduler_assert.svh"

module tels_sva (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire tels_pkg::in_item_t  item,
    input wire logic                strobe,
    input wire tels_pkg::out_item_t result
);

    `TELS_ASSERT_NXT(a_sched_ack, start && !busy && item.opcode == tels_pkg::OP_SCHED, strobe && result.kind == tels_pkg::KIND_ACK && result.last && !busy, "schedule item not acknowledged next cycle")
    `TELS_ASSERT_NXT(a_tick_busy, start && !busy && item.opcode == tels_pkg::OP_TICK, busy, "tick did not start a scan")
    `TELS_ASSERT_IMP(a_deliver_in_scan, strobe && result.kind == tels_pkg::KIND_DELIVER, busy && !result.last, "delivery outside a scan")
    `TELS_ASSERT_IMP(a_scan_end_done, $fell(busy), strobe && result.kind == tels_pkg::KIND_DONE && result.last, "scan ended without done item")

endmodule

bind timed_event_list_scheduler tels_sva u_tels_sva (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire

### dv/tels_checker.sv
`default_nettype none

module tels_checker
    import tels_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire in_item_t             item,
    input  wire logic                 strobe,
    input  wire out_item_t            result,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [31:0]          pwdata,
    input  wire logic [31:0]          prdata,
    input  wire logic                 pready,
    output int                        fail_count,
    output int                        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the block: event list in arrival order, time, start register
    entry_t      event_list[$];
    logic [31:0] clock_now;
    logic [31:0] start_reg;
    out_item_t   due_results[$];
    int          miss_count = 0;

    function automatic string fmt_result(input out_item_t r);
        return $sformatf("kind=%0d acc=%0b rtr=%0d dg=%0d now=%08h last=%0b",
                         r.kind, r.accepted, r.out_router, r.out_datagram,
                         r.now_time, r.last);
    endfunction

    task automatic flag_error(input string msg);
        miss_count++;
        if (miss_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic predict_command(input in_item_t cmd);
        entry_t    kept[$];
        out_item_t r;
        if (cmd.opcode == OP_SCHED) begin
            r = '0;
            r.kind     = KIND_ACK;
            r.now_time = clock_now;
            r.last     = 1'b1;
            if (event_list.size() < CAPACITY_DEF) begin
                event_list.push_back(entry_t'{cmd.event_time, cmd.router_id, cmd.datagram_id});
                r.accepted = 1'b1;
            end
            due_results.push_back(r);
        end
        else begin
            // deliver matches in stored order, keep the rest in order
            foreach (event_list[i]) begin
                if (event_list[i].ev_time == clock_now) begin
                    r = '0;
                    r.kind         = KIND_DELIVER;
                    r.out_router   = event_list[i].router;
                    r.out_datagram = event_list[i].datagram;
                    r.now_time     = clock_now;
                    due_results.push_back(r);
                end
                else
                    kept.push_back(event_list[i]);
            end
            event_list = kept;
            clock_now  = clock_now + 32'd1;
            r = '0;
            r.kind     = KIND_DONE;
            r.now_time = clock_now;
            r.last     = 1'b1;
            due_results.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            event_list.delete();
            due_results.delete();
            clock_now     = '0;
            start_reg     = '0;
            pending_count <= 0;
            fail_count    <= miss_count;
        end
        else begin
            if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_START_TIME) begin
                if (pwrite) begin
                    start_reg = pwdata;
                    clock_now = pwdata;
                end
                else if (prdata !== start_reg)
                    flag_error($sformatf("start_time readback: expected %08h got %08h",
                                         start_reg, prdata));
            end
            if (start && !busy)
                predict_command(item);
            if (strobe) begin
                if (due_results.size() == 0)
                    flag_error({"unexpected result: ", fmt_result(result)});
                else begin
                    want = due_results.pop_front();
                    if (result.kind !== want.kind || result.accepted !== want.accepted ||
                        result.out_router !== want.out_router ||
                        result.out_datagram !== want.out_datagram ||
                        result.now_time !== want.now_time || result.last !== want.last)
                        flag_error({"result mismatch: expected ", fmt_result(want),
                                    " got ", fmt_result(result)});
                end
            end
            pending_count <= due_results.size();
            fail_count    <= miss_count;
        end
    end

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tels_pkg::*;

    // index that decodes to no register; writes there must be dropped
    localparam logic [PADDR_W-3:0] REG_SPARE = 1'b1;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 64;
    localparam int DRAIN_CYCLES    = 40;
    // longest legal quiet stretch: the largest gap plus a full scan,
    // plus the drain at the end; this is many times that
    localparam int WATCHDOG_LIMIT  = 2000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    in_item_t           item;
    logic               strobe;
    out_item_t          result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending_count;

    // stimulus-side bookkeeping only: where the time counter should be, so
    // that most events land a few ticks ahead and actually get delivered
    logic [31:0]        time_guess;
    // times of events that will never come due on their own; a later phase
    // restarts the clock on one of them so they drain out of the list
    logic [31:0]        stale_times[$];
    bit                 burst;
    int unsigned        quiet_cycles;

    timed_event_list_scheduler u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .strobe  (strobe),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tels_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .strobe        (strobe),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: any handshake (item taken, result shown, register access)
    // counts as progress. A hang anywhere ends the run here.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic in_item_t make_cmd(input logic op, input logic [31:0] t,
                                          input logic [7:0] rtr, input logic [15:0] dg);
        in_item_t c;
        c.opcode      = op;
        c.event_time  = t;
        c.router_id   = rtr;
        c.datagram_id = dg;
        return c;
    endfunction

    // Present one item and return at the edge that takes it. start stays
    // high into the next item when no gap is drawn, so back-to-back items
    // never see start dropped and raised in the same step.
    task automatic issue(input in_item_t cmd);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= cmd;
        do @(posedge clk); while (busy);
    endtask

    // Hold off until every expected result has come back. Always waits on
    // the clock before it checks, so start is not written twice in one step.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    // Two-phase register access; psel is dropped and the clock awaited after the
    // access phase so back-to-back accesses do not collide on psel.
    task automatic apb_access(input logic wr, input logic [PADDR_W-3:0] index,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Load start_time (which also reloads the time counter) once the block
    // is idle, then read it back.
    task automatic set_start(input logic [31:0] value);
        wait_drained();
        apb_access(1'b1, REG_START_TIME, value);
        apb_access(1'b0, REG_START_TIME, '0);
        time_guess = value;
    endtask

    // Mostly events due within the next few ticks, some ticks, and a little
    // noise: events already past or scattered over the whole time range.
    task automatic random_command();
        in_item_t    cmd;
        int unsigned pick;
        cmd.event_time  = $urandom;
        cmd.router_id   = 8'($urandom_range(0, 255));
        cmd.datagram_id = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            cmd.opcode = OP_TICK;
            time_guess = time_guess + 32'd1;
        end
        else
        begin
            cmd.opcode = OP_SCHED;
            if (pick < 94)
                cmd.event_time = time_guess + $urandom_range(0, 5);
            else if (pick < 97)
            begin
                cmd.event_time = time_guess - 32'd1;
                stale_times.push_back(cmd.event_time);
            end
            else
                stale_times.push_back(cmd.event_time);
        end
        issue(cmd);
    endtask

    initial
    begin
        logic [31:0] phase_start;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        item    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        burst   = 1'b0;
        time_guess = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Start two ticks short of the wrap; a write to the unused index
        // must leave start_time alone (readback checks it).
        set_start(32'hFFFF_FFFE);
        apb_access(1'b1, REG_SPARE, 32'h1234_5678);
        apb_access(1'b0, REG_START_TIME, '0);

        // field extremes; the two events due first sit second and last in the
        // list, so the first tick has to close gaps and keep the order
        issue(make_cmd(OP_SCHED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
        issue(make_cmd(OP_SCHED, 32'hFFFF_FFFE, 8'h00, 16'h0000));
        issue(make_cmd(OP_SCHED, 32'h0000_0000, 8'hA5, 16'h5A5A));
        issue(make_cmd(OP_SCHED, 32'hFFFF_FFFE, 8'h5A, 16'hA5A5));
        // two deliveries, then one at the wrap to 0, then one at 0,
        // then a tick on an empty list
        repeat (4) issue(make_cmd(OP_TICK, $urandom, 8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535))));

        // fill with events already past (time is 2 now): they stay stored,
        // and the seventeenth is refused on a full list
        for (int i = 0; i <= CAPACITY_DEF; i++)
            issue(make_cmd(OP_SCHED, 32'h0, 8'(i * 15), 16'(i * 4369)));

        // rewind the clock to 0: one tick drains the whole full list
        set_start(32'h0);
        issue(make_cmd(OP_TICK, '0, '0, '0));

        // ---- random phases, each with its own start_time ----
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       phase_start = 32'hFFFF_FFF8;     // crosses the wrap
                2:       phase_start = 32'h0000_0000;
                3:       phase_start = 32'hFFFF_FFFF;
                default: phase_start = (stale_times.size() != 0) ?
                                       stale_times.pop_front() : $urandom;
            endcase
            set_start(phase_start);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // stretches with no gaps now and then
                if (n % 16 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                random_command();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

### timed_event_list_scheduler.f
+incdir+sv
sv/tels_pkg.sv
sv/tels_event_mem.sv
sv/timed_event_list_scheduler.sv
sv/tels_checker.sv
dv/tels_checker.sv
dv/tb_top.sv
